// ----- src/gwc_pkg.sv -----
// Shared constants, types and tables for the GPS week/time-of-week to calendar pipeline.
package gwc_pkg;

  localparam int NumStages = 9;

  localparam int WeekWidth  = 16;
  localparam int TowWidth   = 30;
  localparam int SecWidth   = 21;
  localparam int DaysWidth  = 21;
  localparam int SodWidth   = 17;
  localparam int SohWidth   = 12;
  localparam int DoeWidth   = 18;
  localparam int EraWidth   = 4;
  localparam int YoeWidth   = 9;
  localparam int DoyWidth   = 9;
  localparam int MpWidth    = 4;

  localparam int DayWidth    = 5;
  localparam int MonthWidth  = 4;
  localparam int YearWidth   = 12;
  localparam int Year2Width  = 7;
  localparam int HourWidth   = 5;
  localparam int MinuteWidth = 6;
  localparam int SecondWidth = 6;

  localparam int DaysPerWeek    = 7;
  localparam int SecsPerDay     = 86400;
  localparam int SecsPerHour    = 3600;
  localparam int SecsPerMin     = 60;
  localparam int MaxDayQuot     = 12;
  localparam int EpochDays      = 3657;
  localparam int CivilShift     = 719468;
  localparam int DaysBase       = EpochDays + CivilShift;
  localparam int DaysPerEra     = 146097;
  localparam int MaxEra         = 8;
  localparam int DaysPerCentury = 36524;
  localparam int MaxCentury     = 4;
  localparam int LastDayOfEra   = 146096;
  localparam int DaysPerYear    = 365;
  localparam int YearsPerCent   = 100;
  localparam int MaxYoeCent     = 3;
  localparam int YearsPerEra    = 400;
  localparam int MonthSpan      = 153;
  localparam int MaxMp          = 11;
  localparam int JanIndex       = 10;
  localparam int MarchMonth     = 3;
  localparam int LastYear2      = 99;

  // Exact reciprocals for the constant divisions over the operand ranges used here.
  localparam logic [30:0] MsRecip     = 31'd1099511628;
  localparam int          MsShift     = 40;
  localparam logic [17:0] HourRecip   = 18'd149131;
  localparam int          HourShift   = 29;
  localparam logic [12:0] MinRecip    = 13'd4370;
  localparam int          MinShift    = 18;
  localparam logic [18:0] Quad4Recip  = 19'd367720;
  localparam int          Quad4Shift  = 29;
  localparam logic [18:0] YearRecip   = 19'd367720;
  localparam int          YearShift   = 27;

  typedef logic [NumStages-1:0] stage_en_t;

  // First day of each March-based month, counted from March 1.
  function automatic logic [DoyWidth-1:0] month_offset(input logic [MpWidth-1:0] mp);
    logic [DoyWidth-1:0] off;
    case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

// ----- src/gwc_time_path.sv -----
// Time-of-day pipeline stages: hour, minute and second from seconds of the day.
module gwc_time_path (
  input  logic                                 clk_i,
  input  gwc_pkg::stage_en_t                   en_i,
  input  logic [gwc_pkg::SodWidth-1:0]         sod_i,
  output logic [gwc_pkg::HourWidth-1:0]        hour_o,
  output logic [gwc_pkg::MinuteWidth-1:0]      minute_o,
  output logic [gwc_pkg::SecondWidth-1:0]      second_o
);
  import gwc_pkg::*;

  localparam int HProdWidth = SodWidth + 18;
  localparam int MProdWidth = SohWidth + 13;

  logic [HProdWidth-1:0]  hour_prod;
  logic [MProdWidth-1:0]  min_prod;

  logic [HourWidth-1:0]   hour2_q, hour3_q, hour4_q, hour5_q, hour6_q, hour7_q, hour8_q;
  logic [SodWidth-1:0]    sod2_q;
  logic [SohWidth-1:0]    soh3_q, soh4_q;
  logic [MinuteWidth-1:0] min4_q, min5_q, min6_q, min7_q, min8_q;
  logic [SecondWidth-1:0] sec5_q, sec6_q, sec7_q, sec8_q;

  logic [SodWidth-1:0]    soh3_d;
  logic [SohWidth-1:0]    sec5_d;

  assign hour_prod = HProdWidth'(sod_i) * HProdWidth'(HourRecip);
  assign min_prod  = MProdWidth'(soh3_q) * MProdWidth'(MinRecip);
  assign soh3_d    = sod2_q - SodWidth'(hour2_q) * SodWidth'(SecsPerHour);
  assign sec5_d    = soh4_q - SohWidth'(min4_q) * SohWidth'(SecsPerMin);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      hour2_q <= hour_prod[HourShift +: HourWidth];
      sod2_q  <= sod_i;
    end
    if (en_i[3]) begin
      soh3_q  <= soh3_d[SohWidth-1:0];
      hour3_q <= hour2_q;
    end
    if (en_i[4]) begin
      min4_q  <= min_prod[MinShift +: MinuteWidth];
      soh4_q  <= soh3_q;
      hour4_q <= hour3_q;
    end
    if (en_i[5]) begin
      sec5_q  <= sec5_d[SecondWidth-1:0];
      min5_q  <= min4_q;
      hour5_q <= hour4_q;
    end
    if (en_i[6]) begin
      sec6_q  <= sec5_q;
      min6_q  <= min5_q;
      hour6_q <= hour5_q;
    end
    if (en_i[7]) begin
      sec7_q  <= sec6_q;
      min7_q  <= min6_q;
      hour7_q <= hour6_q;
    end
    if (en_i[8]) begin
      sec8_q  <= sec7_q;
      min8_q  <= min7_q;
      hour8_q <= hour7_q;
    end
  end

  assign hour_o   = hour8_q;
  assign minute_o = min8_q;
  assign second_o = sec8_q;

endmodule

// ----- src/gwc_date_path.sv -----
// Calendar pipeline stages: Gregorian days-to-civil conversion of the shifted day count.
module gwc_date_path (
  input  logic                                 clk_i,
  input  gwc_pkg::stage_en_t                   en_i,
  input  logic [gwc_pkg::DaysWidth-1:0]        days_i,
  output logic [gwc_pkg::DayWidth-1:0]         day_o,
  output logic [gwc_pkg::MonthWidth-1:0]       month_o,
  output logic [gwc_pkg::YearWidth-1:0]        year_o,
  output logic [gwc_pkg::Year2Width-1:0]       year2_o
);
  import gwc_pkg::*;

  localparam int AProdWidth = DoeWidth + 19;
  localparam int YProdWidth = DoeWidth + 19;
  localparam int VWidth     = 11;
  localparam int QuadWidth  = 7;
  localparam int CentWidth  = 3;
  localparam int YcWidth    = 2;

  logic [EraWidth-1:0]   era_d;
  logic [DaysWidth-1:0]  era_base;
  logic [DaysWidth-1:0]  doe_full;
  logic [CentWidth-1:0]  cent_d;
  logic [AProdWidth-1:0] quad_prod;
  logic [DoeWidth-1:0]   t_d;
  logic [YProdWidth-1:0] yoe_prod;
  logic [YcWidth-1:0]    yc_d;
  logic [YoeWidth-1:0]   yc_base;
  logic [DoeWidth-1:0]   off_d;
  logic [YoeWidth-1:0]   ymod_full;
  logic [DoeWidth-1:0]   doy_full;
  logic [DoyWidth-1:0]   doy_d;
  logic [VWidth-1:0]     v_d;
  logic [MpWidth-1:0]    mp_d;
  logic                  late;
  logic [DoyWidth-1:0]   day_full;

  logic [EraWidth-1:0]   era2_q, era3_q, era4_q, era5_q;
  logic [DoeWidth-1:0]   doe2_q, doe3_q, doe4_q, doe5_q, doe6_q;
  logic [QuadWidth-1:0]  quad3_q;
  logic [CentWidth-1:0]  cent3_q;
  logic                  last3_q;
  logic [DoeWidth-1:0]   t4_q;
  logic [YoeWidth-1:0]   yoe5_q;
  logic [DoeWidth-1:0]   off6_q;
  logic [Year2Width-1:0] ymod6_q, ymod7_q;
  logic [YearWidth-1:0]  ybase6_q, ybase7_q;
  logic [DoyWidth-1:0]   doy7_q;
  logic [MpWidth-1:0]    mp7_q;
  logic [DayWidth-1:0]   day8_q;
  logic [MonthWidth-1:0] month8_q;
  logic [YearWidth-1:0]  year8_q;
  logic [Year2Width-1:0] year28_q;

  always_comb begin
    era_d    = '0;
    era_base = '0;
    for (int k = 1; k <= MaxEra; k++) begin
      if (days_i >= DaysWidth'(k * DaysPerEra)) begin
        era_d    = EraWidth'(k);
        era_base = DaysWidth'(k * DaysPerEra);
      end
    end
    doe_full = days_i - era_base;
  end

  always_comb begin
    cent_d = '0;
    for (int k = 1; k <= MaxCentury; k++) begin
      if (doe2_q >= DoeWidth'(k * DaysPerCentury)) begin
        cent_d = CentWidth'(k);
      end
    end
  end

  assign quad_prod = AProdWidth'(doe2_q) * AProdWidth'(Quad4Recip);
  assign t_d       = doe3_q - DoeWidth'(quad3_q) + DoeWidth'(cent3_q) - DoeWidth'(last3_q);
  assign yoe_prod  = YProdWidth'(t4_q) * YProdWidth'(YearRecip);

  always_comb begin
    yc_d    = '0;
    yc_base = '0;
    for (int k = 1; k <= MaxYoeCent; k++) begin
      if (yoe5_q >= YoeWidth'(k * YearsPerCent)) begin
        yc_d    = YcWidth'(k);
        yc_base = YoeWidth'(k * YearsPerCent);
      end
    end
    off_d     = DoeWidth'(yoe5_q) * DoeWidth'(DaysPerYear) + DoeWidth'(yoe5_q >> 2)
              - DoeWidth'(yc_d);
    ymod_full = yoe5_q - yc_base;
  end

  always_comb begin
    doy_full = doe6_q - off6_q;
    doy_d    = doy_full[DoyWidth-1:0];
    v_d      = (VWidth'(doy_d) << 2) + VWidth'(doy_d) + VWidth'(2);
    mp_d     = '0;
    for (int k = 1; k <= MaxMp; k++) begin
      if (v_d >= VWidth'(k * MonthSpan)) begin
        mp_d = MpWidth'(k);
      end
    end
  end

  assign late     = (mp7_q >= MpWidth'(JanIndex));
  assign day_full = doy7_q - month_offset(mp7_q) + DoyWidth'(1);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      era2_q <= era_d;
      doe2_q <= doe_full[DoeWidth-1:0];
    end
    if (en_i[3]) begin
      quad3_q <= quad_prod[Quad4Shift +: QuadWidth];
      cent3_q <= cent_d;
      last3_q <= (doe2_q == DoeWidth'(LastDayOfEra));
      doe3_q  <= doe2_q;
      era3_q  <= era2_q;
    end
    if (en_i[4]) begin
      t4_q   <= t_d;
      doe4_q <= doe3_q;
      era4_q <= era3_q;
    end
    if (en_i[5]) begin
      yoe5_q <= yoe_prod[YearShift +: YoeWidth];
      doe5_q <= doe4_q;
      era5_q <= era4_q;
    end
    if (en_i[6]) begin
      off6_q   <= off_d;
      ymod6_q  <= ymod_full[Year2Width-1:0];
      ybase6_q <= YearWidth'(yoe5_q) + YearWidth'(era5_q) * YearWidth'(YearsPerEra);
      doe6_q   <= doe5_q;
    end
    if (en_i[7]) begin
      doy7_q   <= doy_d;
      mp7_q    <= mp_d;
      ymod7_q  <= ymod6_q;
      ybase7_q <= ybase6_q;
    end
    if (en_i[8]) begin
      day8_q   <= day_full[DayWidth-1:0];
      month8_q <= late ? (mp7_q - MpWidth'(JanIndex - 1)) : (mp7_q + MpWidth'(MarchMonth));
      year8_q  <= ybase7_q + YearWidth'(late);
      if (late && (ymod7_q == Year2Width'(LastYear2))) begin
        year28_q <= '0;
      end else begin
        year28_q <= ymod7_q + Year2Width'(late);
      end
    end
  end

  assign day_o   = day8_q;
  assign month_o = month8_q;
  assign year_o  = year8_q;
  assign year2_o = year28_q;

endmodule

// ----- src/gps_week_tow_to_calendar_core.sv -----
// Top level of the GPS week/time-of-week to calendar date and time-of-day pipeline.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         in_valid_i / in_ready_o   week_number_i, time_of_week_ms_i
//   result    out        out_valid_o / out_ready_i day, month, years, hour, minute, second
//
// One request enters per cycle while in_ready_o is high, and its result is offered once it has
// passed through the nine register stages that split the conversion.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stage holds its contents while the stage after it is full and stalled, and empty
// stages fill behind a stall, so requests keep entering while a result waits, until every stage is full.
module gps_week_tow_to_calendar_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [gwc_pkg::WeekWidth-1:0]        week_number_i,
  input  logic [gwc_pkg::TowWidth-1:0]         time_of_week_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [gwc_pkg::DayWidth-1:0]         day_of_month_o,
  output logic [gwc_pkg::MonthWidth-1:0]       month_number_o,
  output logic [gwc_pkg::YearWidth-1:0]        full_year_o,
  output logic [gwc_pkg::Year2Width-1:0]       year_two_digit_o,
  output logic [gwc_pkg::HourWidth-1:0]        hour_of_day_o,
  output logic [gwc_pkg::MinuteWidth-1:0]      minute_of_hour_o,
  output logic [gwc_pkg::SecondWidth-1:0]      second_of_minute_o
);
  import gwc_pkg::*;

  localparam int MsProdWidth = TowWidth + 31;
  localparam int DqWidth     = 4;

  stage_en_t            adv;
  stage_en_t            valid_q;

  logic [MsProdWidth-1:0] ms_prod;
  logic [DaysWidth-1:0]   dbase_d;
  logic [SecWidth-1:0]    sec0_q;
  logic [DaysWidth-1:0]   dbase0_q;

  logic [DqWidth-1:0]     dq_d;
  logic [SecWidth-1:0]    dq_base;
  logic [SecWidth-1:0]    sod_full;
  logic [SodWidth-1:0]    sod1_q;
  logic [DaysWidth-1:0]   days1_q;

  always_comb begin
    adv[NumStages-1] = ~valid_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = ~valid_q[k] | adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign ms_prod = MsProdWidth'(time_of_week_ms_i) * MsProdWidth'(MsRecip);
  assign dbase_d = DaysWidth'(week_number_i) * DaysWidth'(DaysPerWeek) + DaysWidth'(DaysBase);

  always_comb begin
    dq_d    = '0;
    dq_base = '0;
    for (int k = 1; k <= MaxDayQuot; k++) begin
      if (sec0_q >= SecWidth'(k * SecsPerDay)) begin
        dq_d    = DqWidth'(k);
        dq_base = SecWidth'(k * SecsPerDay);
      end
    end
    sod_full = sec0_q - dq_base;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      sec0_q   <= ms_prod[MsShift +: SecWidth];
      dbase0_q <= dbase_d;
    end
    if (adv[1]) begin
      sod1_q  <= sod_full[SodWidth-1:0];
      days1_q <= dbase0_q + DaysWidth'(dq_d);
    end
  end

  gwc_date_path u_date (
    .clk_i   (clk_i),
    .en_i    (adv),
    .days_i  (days1_q),
    .day_o   (day_of_month_o),
    .month_o (month_number_o),
    .year_o  (full_year_o),
    .year2_o (year_two_digit_o)
  );

  gwc_time_path u_time (
    .clk_i    (clk_i),
    .en_i     (adv),
    .sod_i    (sod1_q),
    .hour_o   (hour_of_day_o),
    .minute_o (minute_of_hour_o),
    .second_o (second_of_minute_o)
  );

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

// ----- bench/gps_week_tow_to_calendar_core_tb.sv -----
// Testbench for the GPS week/time-of-week to calendar date pipeline, checked against a predictor.
`timescale 1ns / 1ps

module gps_week_tow_to_calendar_core_tb;
  import gwc_pkg::*;

  localparam longint unsigned SecsPerWeek = 604800;
  localparam longint unsigned DaySecs     = 86400;
  localparam longint unsigned HourSecs    = 3600;
  localparam longint unsigned EpochOffset = 3657;
  localparam longint unsigned MarchShift  = 719468;
  localparam longint unsigned EraDays     = 146097;
  localparam int              DayMs       = 86400000;
  localparam int              WeekMsMax   = 604799999;
  localparam int              ReportLimit = 10;

  typedef struct packed {
    logic [DayWidth-1:0]    day;
    logic [MonthWidth-1:0]  month;
    logic [YearWidth-1:0]   year;
    logic [Year2Width-1:0]  year2;
    logic [HourWidth-1:0]   hour;
    logic [MinuteWidth-1:0] minute;
    logic [SecondWidth-1:0] second;
  } calendar_t;

  class calendar_board;
    calendar_t pending_dates[$];
    int        mismatches;

    function calendar_t predict_calendar(logic [WeekWidth-1:0] week, logic [TowWidth-1:0] tow);
      longint unsigned secs, days, era, doe, yoe, year, doy, mp, mday, mon, sod;
      calendar_t c;
      secs = 64'(week) * SecsPerWeek + 64'(tow) / 64'd1000;
      days = EpochOffset + secs / DaySecs + MarchShift;
      era  = days / EraDays;
      doe  = days - era * EraDays;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      year = yoe + era * 400;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      mday = doy - (153 * mp + 2) / 5 + 1;
      mon  = (mp < 10) ? mp + 3 : mp - 9;
      if (mon <= 2) begin
        year = year + 1;
      end
      sod      = secs % DaySecs;
      c.day    = mday[DayWidth-1:0];
      c.month  = mon[MonthWidth-1:0];
      c.year   = year[YearWidth-1:0];
      c.year2  = 7'(year % 100);
      c.hour   = 5'(sod / HourSecs);
      c.minute = 6'((sod % HourSecs) / 60);
      c.second = 6'(sod % 60);
      return c;
    endfunction

    function void note_request(logic [WeekWidth-1:0] week, logic [TowWidth-1:0] tow);
      pending_dates.push_back(predict_calendar(week, tow));
    endfunction

    function void check_result(calendar_t got);
      calendar_t want;
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month, got.day,
                   got.hour, got.minute, got.second);
        end
        return;
      end
      want = pending_dates.pop_front();
      if (got.day !== want.day || got.month !== want.month || got.year !== want.year ||
          got.year2 !== want.year2 || got.hour !== want.hour ||
          got.minute !== want.minute || got.second !== want.second) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("mismatch: expected %0d-%0d-%0d (%0d) %0d:%0d:%0d, got %0d-%0d-%0d (%0d) %0d:%0d:%0d",
                   want.year, want.month, want.day, want.year2, want.hour, want.minute,
                   want.second, got.year, got.month, got.day, got.year2, got.hour,
                   got.minute, got.second);
        end
      end
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [WeekWidth-1:0]   week_number_i = '0;
  logic [TowWidth-1:0]    time_of_week_ms_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [DayWidth-1:0]    day_of_month_o;
  logic [MonthWidth-1:0]  month_number_o;
  logic [YearWidth-1:0]   full_year_o;
  logic [Year2Width-1:0]  year_two_digit_o;
  logic [HourWidth-1:0]   hour_of_day_o;
  logic [MinuteWidth-1:0] minute_of_hour_o;
  logic [SecondWidth-1:0] second_of_minute_o;

  calendar_board board = new();
  int send_idle_pct = 0;
  int stall_pct = 0;

  gps_week_tow_to_calendar_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .week_number_i      (week_number_i),
    .time_of_week_ms_i  (time_of_week_ms_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .day_of_month_o     (day_of_month_o),
    .month_number_o     (month_number_o),
    .full_year_o        (full_year_o),
    .year_two_digit_o   (year_two_digit_o),
    .hour_of_day_o      (hour_of_day_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .second_of_minute_o (second_of_minute_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result('{day_of_month_o, month_number_o, full_year_o, year_two_digit_o,
                           hour_of_day_o, minute_of_hour_o, second_of_minute_o});
    end
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_request(input logic [WeekWidth-1:0] week, input logic [TowWidth-1:0] tow);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    week_number_i     <= week;
    time_of_week_ms_i <= tow;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(week, tow);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  function automatic logic [WeekWidth-1:0] random_week();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    return WeekWidth'($urandom_range(0, 65535));
  endfunction

  function automatic logic [TowWidth-1:0] random_tow();
    int pick;
    int edge_ms[5] = '{0, 999, 1000, 86399000, 86399999};
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      return TowWidth'($urandom_range(0, WeekMsMax));
    end else if (pick == 7) begin
      return TowWidth'($urandom);
    end
    return TowWidth'($urandom_range(0, 11) * DayMs + edge_ms[$urandom_range(0, 4)]);
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Epoch, sub-second truncation, end of day, the last millisecond of a week and a new year.
    send_request(16'd0, 30'd0);
    send_request(16'd0, 30'd999);
    send_request(16'd0, 30'd1000);
    send_request(16'd0, 30'd86399999);
    send_request(16'd0, 30'd604799999);
    send_request(16'd51, 30'd345599000);
    send_request(16'd51, 30'd345600000);
    // Leap day of a leap century, a skipped century leap day and an era boundary.
    send_request(16'd1051, 30'd259199000);
    send_request(16'd1051, 30'd259200000);
    send_request(16'd6269, 30'd86399000);
    send_request(16'd6269, 30'd86400000);
    send_request(16'd21922, 30'd259199999);
    send_request(16'd21922, 30'd259200000);
    // Time of week past one week carries into later days; the top week number and patterned inputs follow.
    send_request(16'd0, 30'd604800000);
    send_request(16'd1000, 30'h3FFFFFFF);
    send_request(16'hFFFF, 30'd0);
    send_request(16'hFFFF, 30'd604799999);
    send_request(16'hFFFF, 30'h3FFFFFFF);
    send_request(16'h5555, 30'h15555555);
    send_request(16'hAAAA, 30'h2AAAAAAA);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      for (int n = 0; n < 420; n++) begin
        if (n == 200 && phase >= 2) begin
          drain_requests();
        end
        send_request(random_week(), random_tow());
      end
    end
    drain_requests();
    repeat (30) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
